FILE: rtl/core/tiled_scan_lod_task_generator_defines.svh
// Assertion macros shared by the tiled scan task generator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TILED_SCAN_LOD_TASK_GENERATOR_DEFINES_SVH
`define TILED_SCAN_LOD_TASK_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSLG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tslg_pkg.sv
// Package for the tiled scan task generator: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package tslg_pkg;

    localparam int COORD_BITS_DEF = 22;
    localparam int TILE_BITS      = 13;
    localparam int SECTION_BITS   = 8;
    localparam int RADIUS_BITS    = 16;
    localparam int RADIUS_COUNT   = 4;
    localparam int FACTOR_BITS    = 4;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [TILE_BITS-1:0] TILE_SIZE_RESET = 13'd16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_SIZE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_X      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_Z      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DETAIL_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_0      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_1      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_2      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_3      = 3'd7;

    localparam logic [FACTOR_BITS-1:0] FACTOR_ZERO  = 4'd0;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE   = 4'd1;
    localparam logic [FACTOR_BITS-1:0] FACTOR_TWO   = 4'd2;
    localparam logic [FACTOR_BITS-1:0] FACTOR_FOUR  = 4'd4;
    localparam logic [FACTOR_BITS-1:0] FACTOR_EIGHT = 4'd8;

    typedef logic [RADIUS_COUNT-1:0][RADIUS_BITS-1:0] t_radius_set;

    typedef struct packed {
        logic tile_first;
        logic tile_last;
        logic region_last;
    } t_marks;

endpackage

FILE: rtl/core/tslg_traverse.sv
// Traversal state of the tiled scan: latches the region on a load beat and
// emits one task position with its tile and region marks per step beat while a scan is running.
// Depends on tslg_pkg.
`timescale 1ns / 1ps

module tslg_traverse #(
    parameter int COORD_BITS = tslg_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [tslg_pkg::TILE_BITS-1:0]        i_tile_size,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_operation,
    input  logic signed [COORD_BITS-1:0]          i_x_first,
    input  logic signed [COORD_BITS-1:0]          i_x_last,
    input  logic signed [COORD_BITS-1:0]          i_z_first,
    input  logic signed [COORD_BITS-1:0]          i_z_last,
    input  logic signed [tslg_pkg::SECTION_BITS-1:0] i_section_first,
    input  logic signed [tslg_pkg::SECTION_BITS-1:0] i_section_last,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [COORD_BITS-1:0]          o_x,
    output logic signed [COORD_BITS-1:0]          o_z,
    output logic signed [tslg_pkg::SECTION_BITS-1:0] o_section,
    output tslg_pkg::t_marks                      o_marks
);
    import tslg_pkg::*;

    localparam int SW = ((COORD_BITS > TILE_BITS) ? COORD_BITS : TILE_BITS) + 2;

    logic signed [COORD_BITS-1:0]   r_x_org, r_z_org, r_cx, r_cz;
    logic signed [COORD_BITS-1:0]   r_bx1, r_bz0, r_bz1;
    logic signed [SECTION_BITS-1:0] r_cs, r_bs0, r_bs1;
    logic                           r_running;
    logic                           r_valid;
    logic signed [COORD_BITS-1:0]   r_task_x, r_task_z;
    logic signed [SECTION_BITS-1:0] r_task_sec;
    t_marks                         r_marks;

    logic                           en;
    logic                           accept;
    logic [TILE_BITS-1:0]           eff_ts;
    logic signed [SW-1:0]           ts_s;
    logic signed [SW-1:0]           x_org_nxt, z_org_nxt;
    logic signed [SW-1:0]           x_end, z_end;
    logic signed [SW-1:0]           cx_s, cz_s;
    logic                           x_more, z_more;
    t_marks                         marks;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    assign eff_ts    = (i_tile_size == '0) ? TILE_BITS'(1) : i_tile_size;
    assign ts_s      = SW'(eff_ts);
    assign x_org_nxt = SW'(r_x_org) + ts_s;
    assign z_org_nxt = SW'(r_z_org) + ts_s;
    assign x_more    = x_org_nxt <= SW'(r_bx1);
    assign z_more    = z_org_nxt <= SW'(r_bz1);
    assign cx_s      = SW'(r_cx);
    assign cz_s      = SW'(r_cz);

    always_comb begin
        x_end = x_org_nxt - SW'(1);
        if (SW'(r_bx1) < x_end) begin
            x_end = SW'(r_bx1);
        end
        z_end = z_org_nxt - SW'(1);
        if (SW'(r_bz1) < z_end) begin
            z_end = SW'(r_bz1);
        end
    end

    always_comb begin
        marks.tile_first  = (r_cx == r_x_org) && (r_cz == r_z_org) && (r_cs == r_bs0);
        marks.tile_last   = (cx_s >= x_end) && (cz_s >= z_end) && (r_cs >= r_bs1);
        marks.region_last = marks.tile_last && !x_more && !z_more;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_org   <= '0;
            r_z_org   <= '0;
            r_cx      <= '0;
            r_cz      <= '0;
            r_cs      <= '0;
            r_bx1     <= '0;
            r_bz0     <= '0;
            r_bz1     <= '0;
            r_bs0     <= '0;
            r_bs1     <= '0;
            r_running <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (en) begin
                r_valid <= accept && (i_operation == OP_STEP) && r_running;
            end
            if (accept && (i_operation == OP_LOAD)) begin
                r_bx1     <= i_x_last;
                r_bz0     <= i_z_first;
                r_bz1     <= i_z_last;
                r_bs0     <= i_section_first;
                r_bs1     <= i_section_last;
                r_x_org   <= i_x_first;
                r_z_org   <= i_z_first;
                r_cx      <= i_x_first;
                r_cz      <= i_z_first;
                r_cs      <= i_section_first;
                r_running <= (i_x_first <= i_x_last) && (i_z_first <= i_z_last)
                             && (i_section_first <= i_section_last);
            end else if (accept && r_running) begin
                if (r_cs < r_bs1) begin
                    r_cs <= r_cs + SECTION_BITS'(1);
                end else begin
                    r_cs <= r_bs0;
                    if (cz_s < z_end) begin
                        r_cz <= r_cz + COORD_BITS'(1);
                    end else begin
                        r_cz <= r_z_org;
                        if (cx_s < x_end) begin
                            r_cx <= r_cx + COORD_BITS'(1);
                        end else if (z_more) begin
                            r_z_org <= z_org_nxt[COORD_BITS-1:0];
                            r_cz    <= z_org_nxt[COORD_BITS-1:0];
                            r_cx    <= r_x_org;
                        end else begin
                            r_z_org <= r_bz0;
                            r_cz    <= r_bz0;
                            if (x_more) begin
                                r_x_org <= x_org_nxt[COORD_BITS-1:0];
                                r_cx    <= x_org_nxt[COORD_BITS-1:0];
                            end else begin
                                r_cx      <= r_x_org;
                                r_running <= 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == OP_STEP) && r_running) begin
            r_task_x   <= r_cx;
            r_task_z   <= r_cz;
            r_task_sec <= r_cs;
            r_marks    <= marks;
        end
    end

    assign o_valid   = r_valid;
    assign o_x       = r_task_x;
    assign o_z       = r_task_z;
    assign o_section = r_task_sec;
    assign o_marks   = r_marks;

endmodule

FILE: rtl/core/tslg_classify.sv
// Three-stage detail classifier: centre offsets, squares, then the sum
// compared against the squared radii into the result register.
// Depends on tslg_pkg.
`timescale 1ns / 1ps

module tslg_classify #(
    parameter int COORD_BITS = tslg_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [COORD_BITS-1:0]          i_centre_x,
    input  logic signed [COORD_BITS-1:0]          i_centre_z,
    input  logic                                  i_detail_enable,
    input  tslg_pkg::t_radius_set                 i_radius,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_BITS-1:0]          i_x,
    input  logic signed [COORD_BITS-1:0]          i_z,
    input  logic signed [tslg_pkg::SECTION_BITS-1:0] i_section,
    input  tslg_pkg::t_marks                      i_marks,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [COORD_BITS-1:0]          o_x,
    output logic signed [COORD_BITS-1:0]          o_z,
    output logic signed [tslg_pkg::SECTION_BITS-1:0] o_section,
    output logic [tslg_pkg::FACTOR_BITS-1:0]      o_factor,
    output tslg_pkg::t_marks                      o_marks
);
    import tslg_pkg::*;

    localparam int DXW = COORD_BITS + 1;
    localparam int PW  = 2 * DXW;
    localparam int DW  = PW + 1;
    localparam int RRW = 2 * RADIUS_BITS;
    localparam int CW  = (DW > RRW) ? DW : RRW;

    logic                           r_v2, r_v3, r_v4;
    logic signed [COORD_BITS-1:0]   r_x2, r_z2, r_x3, r_z3, r_x4, r_z4;
    logic signed [SECTION_BITS-1:0] r_sec2, r_sec3, r_sec4;
    t_marks                         r_mk2, r_mk3, r_mk4;
    logic signed [DXW-1:0]          r_dx, r_dz;
    logic [PW-1:0]                  r_sq_x, r_sq_z;
    logic [RADIUS_COUNT-1:0][RRW-1:0] r_rr;
    logic [FACTOR_BITS-1:0]         r_factor;

    logic                           en2, en3, en4;
    logic signed [PW-1:0]           prod_x, prod_z;
    logic [CW-1:0]                  d2;
    logic [FACTOR_BITS-1:0]         factor;

    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign o_stall = !en2;

    assign prod_x = PW'(r_dx) * PW'(r_dx);
    assign prod_z = PW'(r_dz) * PW'(r_dz);
    assign d2     = CW'(r_sq_x) + CW'(r_sq_z);

    always_comb begin
        if (!i_detail_enable) begin
            factor = FACTOR_ZERO;
        end else if (d2 <= CW'(r_rr[0])) begin
            factor = FACTOR_ZERO;
        end else if (d2 <= CW'(r_rr[1])) begin
            factor = FACTOR_ONE;
        end else if (d2 <= CW'(r_rr[2])) begin
            factor = FACTOR_TWO;
        end else if (d2 <= CW'(r_rr[3])) begin
            factor = FACTOR_FOUR;
        end else begin
            factor = FACTOR_EIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_valid) begin
            r_dx   <= DXW'(i_x) - DXW'(i_centre_x);
            r_dz   <= DXW'(i_z) - DXW'(i_centre_z);
            r_x2   <= i_x;
            r_z2   <= i_z;
            r_sec2 <= i_section;
            r_mk2  <= i_marks;
        end
        if (en3 && r_v2) begin
            r_sq_x <= prod_x;
            r_sq_z <= prod_z;
            for (int k = 0; k < RADIUS_COUNT; k++) begin
                r_rr[k] <= RRW'(i_radius[k]) * RRW'(i_radius[k]);
            end
            r_x3   <= r_x2;
            r_z3   <= r_z2;
            r_sec3 <= r_sec2;
            r_mk3  <= r_mk2;
        end
        if (en4 && r_v3) begin
            r_factor <= factor;
            r_x4     <= r_x3;
            r_z4     <= r_z3;
            r_sec4   <= r_sec3;
            r_mk4    <= r_mk3;
        end
    end

    assign o_valid   = r_v4;
    assign o_x       = r_x4;
    assign o_z       = r_z4;
    assign o_section = r_sec4;
    assign o_factor  = r_factor;
    assign o_marks   = r_mk4;

endmodule

FILE: rtl/core/tiled_scan_lod_task_generator.sv
// Tiled scan task generator. A load beat (operation 0) latches an inclusive
// X, Z and section region and restarts the scan; each step beat (operation 1)
// emits the next task, tiles visited X-major and cells inside a tile in X, Z,
// section order, with a detail factor from the squared distance to the centre.
// One beat is taken per cycle in and one task given per cycle out while the
// receiver does not stall; a task passes the traversal register and three
// classifier stages before it is presented. Load beats, and steps past the
// region end or before a non-empty region is loaded, give no task.
// The user writes configuration through the plain write port while the block idles; the block does not enforce it.
// Depends on tslg_pkg, tslg_traverse, tslg_classify and the defines header.
`timescale 1ns / 1ps
`include "tiled_scan_lod_task_generator_defines.svh"

module tiled_scan_lod_task_generator #(
    parameter int COORD_BITS = tslg_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [tslg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [((COORD_BITS > tslg_pkg::RADIUS_BITS) ? COORD_BITS
                  : tslg_pkg::RADIUS_BITS)-1:0]   i_cfg_wr_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_operation,
    input  logic signed [COORD_BITS-1:0]          i_x_first,
    input  logic signed [COORD_BITS-1:0]          i_x_last,
    input  logic signed [COORD_BITS-1:0]          i_z_first,
    input  logic signed [COORD_BITS-1:0]          i_z_last,
    input  logic signed [tslg_pkg::SECTION_BITS-1:0] i_section_first,
    input  logic signed [tslg_pkg::SECTION_BITS-1:0] i_section_last,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [COORD_BITS-1:0]          o_task_x,
    output logic signed [COORD_BITS-1:0]          o_task_z,
    output logic signed [tslg_pkg::SECTION_BITS-1:0] o_task_section,
    output logic [tslg_pkg::FACTOR_BITS-1:0]      o_detail_factor,
    output logic                                  o_tile_first,
    output logic                                  o_tile_last,
    output logic                                  o_region_last
);
    import tslg_pkg::*;

    logic [TILE_BITS-1:0]         r_cfg_tile_size;
    logic signed [COORD_BITS-1:0] r_cfg_centre_x, r_cfg_centre_z;
    logic                         r_cfg_detail_enable;
    t_radius_set                  r_cfg_radius;

    logic                           t_valid, t_stall;
    logic signed [COORD_BITS-1:0]   t_x, t_z;
    logic signed [SECTION_BITS-1:0] t_section;
    t_marks                         t_mk;
    t_marks                         out_mk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tile_size     <= TILE_SIZE_RESET;
            r_cfg_centre_x      <= '0;
            r_cfg_centre_z      <= '0;
            r_cfg_detail_enable <= 1'b0;
            r_cfg_radius        <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TILE_SIZE:     r_cfg_tile_size     <= i_cfg_wr_data[TILE_BITS-1:0];
                CFG_CENTRE_X:      r_cfg_centre_x      <= i_cfg_wr_data[COORD_BITS-1:0];
                CFG_CENTRE_Z:      r_cfg_centre_z      <= i_cfg_wr_data[COORD_BITS-1:0];
                CFG_DETAIL_ENABLE: r_cfg_detail_enable <= i_cfg_wr_data[0];
                CFG_RADIUS_0:      r_cfg_radius[0]     <= i_cfg_wr_data[RADIUS_BITS-1:0];
                CFG_RADIUS_1:      r_cfg_radius[1]     <= i_cfg_wr_data[RADIUS_BITS-1:0];
                CFG_RADIUS_2:      r_cfg_radius[2]     <= i_cfg_wr_data[RADIUS_BITS-1:0];
                CFG_RADIUS_3:      r_cfg_radius[3]     <= i_cfg_wr_data[RADIUS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    tslg_traverse #(
        .COORD_BITS (COORD_BITS)
    ) u_traverse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tile_size     (r_cfg_tile_size),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_x_first       (i_x_first),
        .i_x_last        (i_x_last),
        .i_z_first       (i_z_first),
        .i_z_last        (i_z_last),
        .i_section_first (i_section_first),
        .i_section_last  (i_section_last),
        .o_valid         (t_valid),
        .i_stall         (t_stall),
        .o_x             (t_x),
        .o_z             (t_z),
        .o_section       (t_section),
        .o_marks         (t_mk)
    );

    tslg_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_centre_x      (r_cfg_centre_x),
        .i_centre_z      (r_cfg_centre_z),
        .i_detail_enable (r_cfg_detail_enable),
        .i_radius        (r_cfg_radius),
        .i_valid         (t_valid),
        .o_stall         (t_stall),
        .i_x             (t_x),
        .i_z             (t_z),
        .i_section       (t_section),
        .i_marks         (t_mk),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_x             (o_task_x),
        .o_z             (o_task_z),
        .o_section       (o_task_section),
        .o_factor        (o_detail_factor),
        .o_marks         (out_mk)
    );

    assign o_tile_first  = out_mk.tile_first;
    assign o_tile_last   = out_mk.tile_last;
    assign o_region_last = out_mk.region_last;

    `TSLG_ASSERT_IMPLIES(a_factor_code, o_valid, $onehot0(o_detail_factor), "bad detail factor")
    `TSLG_ASSERT_IMPLIES(a_factor_off, o_valid && !r_cfg_detail_enable,
        o_detail_factor == FACTOR_ZERO, "detail factor set while detail is off")
    `TSLG_ASSERT_IMPLIES(a_region_in_tile, o_valid && o_region_last, o_tile_last,
        "region end outside a tile end")
    `TSLG_ASSERT_NEXT(a_load_no_task, i_valid && !o_stall && (i_operation == OP_LOAD),
        !t_valid, "load beat produced a task")

endmodule

FILE: test/tb_tiled_scan_lod_task_generator.sv
// Self-checking testbench for tiled_scan_lod_task_generator: directed and random
// load and step beats, with a scan predictor in the bench that checks every task.
// Depends on tslg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_tiled_scan_lod_task_generator;
    import tslg_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int SB = SECTION_BITS;
    localparam int CFG_W = (CB > RADIUS_BITS) ? CB : RADIUS_BITS;
    localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint SEC_MAX = (longint'(1) << (SB - 1)) - 1;
    localparam longint SEC_MIN = -SEC_MAX - 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SEGMENT_ITEMS = 32;
    localparam int SEGMENTS_PER_PHASE = 2;

    typedef struct {
        logic                 op;
        logic signed [CB-1:0] x_first;
        logic signed [CB-1:0] x_last;
        logic signed [CB-1:0] z_first;
        logic signed [CB-1:0] z_last;
        logic signed [SB-1:0] sec_first;
        logic signed [SB-1:0] sec_last;
    } scan_beat_t;

    typedef struct {
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   z;
        logic signed [SB-1:0]   section;
        logic [FACTOR_BITS-1:0] factor;
        logic                   tile_first;
        logic                   tile_last;
        logic                   region_last;
    } lod_task_t;

    typedef struct {
        longint tile;
        longint cx;
        longint cz;
        longint detail;
        longint r0;
        longint r1;
        longint r2;
        longint r3;
    } reg_set_t;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_wr_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_operation = OP_LOAD;
    logic signed [CB-1:0]      i_x_first = '0;
    logic signed [CB-1:0]      i_x_last = '0;
    logic signed [CB-1:0]      i_z_first = '0;
    logic signed [CB-1:0]      i_z_last = '0;
    logic signed [SB-1:0]      i_section_first = '0;
    logic signed [SB-1:0]      i_section_last = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [CB-1:0]      o_task_x;
    logic signed [CB-1:0]      o_task_z;
    logic signed [SB-1:0]      o_task_section;
    logic [FACTOR_BITS-1:0]    o_detail_factor;
    logic                      o_tile_first;
    logic                      o_tile_last;
    logic                      o_region_last;

    int send_idle_pct = 6;
    int recv_idle_pct = 48;
    bit long_hold = 1'b0;
    int hold_cnt = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int loads_sent = 0;
    int tasks_checked = 0;
    int settings_applied = 0;

    longint cfg_tile_size = TILE_SIZE_RESET;
    longint cfg_centre_x = 0;
    longint cfg_centre_z = 0;
    longint cfg_detail = 0;
    longint cfg_radius[4] = '{0, 0, 0, 0};

    longint scan_x_origin = 0;
    longint scan_z_origin = 0;
    longint cur_x = 0;
    longint cur_z = 0;
    longint cur_sec = 0;
    longint lim_x[2] = '{0, 0};
    longint lim_z[2] = '{0, 0};
    longint lim_sec[2] = '{0, 0};
    bit     scan_running = 1'b0;

    lod_task_t pending_tasks[$];

    tiled_scan_lod_task_generator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d tasks outstanding", $time, pending_tasks.size());
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver either stalls at random or, while a long hold is requested,
    // stalls without a break until its own hold counter runs out.
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!long_hold) begin
                hold_cnt <= 0;
            end
        end
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_tasks
        lod_task_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tasks.size() == 0) begin
                $display("%0t: unexpected task, expected none, actual x %0d z %0d section %0d",
                         $time, o_task_x, o_task_z, o_task_section);
                mismatches++;
            end else begin
                want = pending_tasks.pop_front();
                check_field("task_x", want.x, o_task_x);
                check_field("task_z", want.z, o_task_z);
                check_field("task_section", want.section, o_task_section);
                check_field("detail_factor", want.factor, o_detail_factor);
                check_field("tile_first", want.tile_first, o_tile_first);
                check_field("tile_last", want.tile_last, o_tile_last);
                check_field("region_last", want.region_last, o_region_last);
                tasks_checked++;
            end
        end
    end

    function automatic logic [FACTOR_BITS-1:0] detail_factor(input longint x, input longint z);
        longint dx;
        longint dz;
        longint d2;
        dx = x - cfg_centre_x;
        dz = z - cfg_centre_z;
        d2 = dx * dx + dz * dz;
        if (cfg_detail == 0) return FACTOR_ZERO;
        if (d2 <= cfg_radius[0] * cfg_radius[0]) return FACTOR_ZERO;
        if (d2 <= cfg_radius[1] * cfg_radius[1]) return FACTOR_ONE;
        if (d2 <= cfg_radius[2] * cfg_radius[2]) return FACTOR_TWO;
        if (d2 <= cfg_radius[3] * cfg_radius[3]) return FACTOR_FOUR;
        return FACTOR_EIGHT;
    endfunction

    task automatic advance_scan(input scan_beat_t b);
        longint ts;
        longint x_end;
        longint z_end;
        lod_task_t t;
        if (b.op == OP_LOAD) begin
            lim_x[0] = b.x_first;
            lim_x[1] = b.x_last;
            lim_z[0] = b.z_first;
            lim_z[1] = b.z_last;
            lim_sec[0] = b.sec_first;
            lim_sec[1] = b.sec_last;
            scan_x_origin = lim_x[0];
            scan_z_origin = lim_z[0];
            cur_x = lim_x[0];
            cur_z = lim_z[0];
            cur_sec = lim_sec[0];
            scan_running = lim_x[0] <= lim_x[1] && lim_z[0] <= lim_z[1] &&
                           lim_sec[0] <= lim_sec[1];
            return;
        end
        if (!scan_running) return;

        ts = (cfg_tile_size == 0) ? 1 : cfg_tile_size;
        x_end = (scan_x_origin + ts - 1 < lim_x[1]) ? scan_x_origin + ts - 1 : lim_x[1];
        z_end = (scan_z_origin + ts - 1 < lim_z[1]) ? scan_z_origin + ts - 1 : lim_z[1];

        t.x = cur_x[CB-1:0];
        t.z = cur_z[CB-1:0];
        t.section = cur_sec[SB-1:0];
        t.factor = detail_factor(cur_x, cur_z);
        t.tile_first = cur_x == scan_x_origin && cur_z == scan_z_origin &&
                       cur_sec == lim_sec[0];
        t.tile_last = cur_x >= x_end && cur_z >= z_end && cur_sec >= lim_sec[1];
        t.region_last = t.tile_last && scan_x_origin + ts > lim_x[1] &&
                        scan_z_origin + ts > lim_z[1];
        pending_tasks = {pending_tasks, t};

        if (cur_sec < lim_sec[1]) begin
            cur_sec++;
        end else begin
            cur_sec = lim_sec[0];
            if (cur_z < z_end) begin
                cur_z++;
            end else begin
                cur_z = scan_z_origin;
                if (cur_x < x_end) begin
                    cur_x++;
                end else begin
                    if (scan_z_origin + ts <= lim_z[1]) begin
                        scan_z_origin += ts;
                    end else begin
                        scan_z_origin = lim_z[0];
                        if (scan_x_origin + ts <= lim_x[1]) begin
                            scan_x_origin += ts;
                        end else begin
                            scan_running = 1'b0;
                        end
                    end
                    cur_x = scan_x_origin;
                    cur_z = scan_z_origin;
                end
            end
        end
    endtask

    function automatic longint rand_signed(input int bits);
        longint v;
        v = longint'($urandom) << (64 - bits);
        return v >>> (64 - bits);
    endfunction

    function automatic longint clamp_first(input longint want, input longint span,
                                           input longint lo, input longint hi);
        if (want < lo) return lo;
        if (want > hi - span) return hi - span;
        return want;
    endfunction

    task automatic send_beat(input scan_beat_t b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_operation <= b.op;
        i_x_first <= b.x_first;
        i_x_last <= b.x_last;
        i_z_first <= b.z_first;
        i_z_last <= b.z_last;
        i_section_first <= b.sec_first;
        i_section_last <= b.sec_last;
        do @(posedge i_clk); while (o_stall);
        advance_scan(b);
        beats_sent++;
    endtask

    task automatic send_load(input longint xf, input longint xl, input longint zf,
                             input longint zl, input longint sf, input longint sl);
        scan_beat_t b;
        b.op = OP_LOAD;
        b.x_first = xf[CB-1:0];
        b.x_last = xl[CB-1:0];
        b.z_first = zf[CB-1:0];
        b.z_last = zl[CB-1:0];
        b.sec_first = sf[SB-1:0];
        b.sec_last = sl[SB-1:0];
        send_beat(b);
        loads_sent++;
    endtask

    task automatic send_steps(input int count);
        scan_beat_t b;
        for (int i = 0; i < count; i++) begin
            b.op = OP_STEP;
            b.x_first = CB'($urandom);
            b.x_last = CB'($urandom);
            b.z_first = CB'($urandom);
            b.z_last = CB'($urandom);
            b.sec_first = SB'($urandom);
            b.sec_last = SB'($urandom);
            send_beat(b);
        end
    endtask

    // A step may leave the block busy with no task to show for it, so the
    // pipeline is left to drain further once nothing is outstanding.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_tasks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input longint value);
        logic [CFG_W-1:0] word;
        word = value[CFG_W-1:0];
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wr_data <= word;
        @(posedge i_clk);
        case (index)
            CFG_TILE_SIZE:     cfg_tile_size = word[TILE_BITS-1:0];
            CFG_CENTRE_X:      cfg_centre_x = $signed(word[CB-1:0]);
            CFG_CENTRE_Z:      cfg_centre_z = $signed(word[CB-1:0]);
            CFG_DETAIL_ENABLE: cfg_detail = word[0];
            CFG_RADIUS_0:      cfg_radius[0] = word[RADIUS_BITS-1:0];
            CFG_RADIUS_1:      cfg_radius[1] = word[RADIUS_BITS-1:0];
            CFG_RADIUS_2:      cfg_radius[2] = word[RADIUS_BITS-1:0];
            CFG_RADIUS_3:      cfg_radius[3] = word[RADIUS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(input reg_set_t s);
        wait_idle();
        write_reg(CFG_TILE_SIZE, s.tile);
        write_reg(CFG_CENTRE_X, s.cx);
        write_reg(CFG_CENTRE_Z, s.cz);
        write_reg(CFG_DETAIL_ENABLE, s.detail);
        write_reg(CFG_RADIUS_0, s.r0);
        write_reg(CFG_RADIUS_1, s.r1);
        write_reg(CFG_RADIUS_2, s.r2);
        write_reg(CFG_RADIUS_3, s.r3);
        i_cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    function automatic reg_set_t random_setting();
        reg_set_t s;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) s.tile = 0;
        else if (pick == 1) s.tile = $urandom_range(8191);
        else if (pick == 2) s.tile = 4096;
        else s.tile = $urandom_range(1, 4);
        s.cx = $urandom_range(1) ? rand_signed(CB) : longint'($urandom_range(40)) - 20;
        s.cz = $urandom_range(1) ? rand_signed(CB) : longint'($urandom_range(40)) - 20;
        s.detail = ($urandom_range(3) != 0);
        if ($urandom_range(4) == 0) begin
            s.r0 = $urandom_range(65535);
            s.r1 = $urandom_range(65535);
            s.r2 = $urandom_range(65535);
            s.r3 = $urandom_range(65535);
        end else begin
            s.r0 = $urandom_range(2);
            s.r1 = s.r0 + $urandom_range(3);
            s.r2 = s.r1 + $urandom_range(3);
            s.r3 = s.r2 + $urandom_range(3);
        end
        return s;
    endfunction

    // Mostly small regions near the detail centre, walked to the end or cut
    // short; some loads carry random bounds, and some steps continue a region.
    task automatic run_region(output int used);
        int     pick;
        int     sx;
        int     sz;
        int     ss;
        int     cells;
        int     steps;
        longint xf;
        longint zf;
        longint sf;
        pick = $urandom_range(9);
        sx = $urandom_range(5);
        sz = $urandom_range(5);
        ss = $urandom_range(3);
        cells = (sx + 1) * (sz + 1) * (ss + 1);
        steps = $urandom_range(1) ? cells + $urandom_range(2) : $urandom_range(1, cells);
        used = steps;
        if (pick < 7) begin
            xf = clamp_first(cfg_centre_x + longint'($urandom_range(16)) - 8, sx,
                             COORD_MIN, COORD_MAX);
            zf = clamp_first(cfg_centre_z + longint'($urandom_range(16)) - 8, sz,
                             COORD_MIN, COORD_MAX);
            sf = clamp_first(rand_signed(SB), ss, SEC_MIN, SEC_MAX);
            send_load(xf, xf + sx, zf, zf + sz, sf, sf + ss);
            used++;
        end else if (pick < 9) begin
            send_load(rand_signed(CB), rand_signed(CB), rand_signed(CB), rand_signed(CB),
                      rand_signed(SB), rand_signed(SB));
            used++;
        end
        send_steps(steps);
    endtask

    task automatic test_unloaded_and_empty();
        send_steps(1);
        send_load(0, -1, 0, 0, 0, 0);
        send_load(0, 0, 5, 4, 0, 0);
        send_load(0, 0, 0, 0, 1, 0);
        send_steps(1);
    endtask

    task automatic test_tile_walk();
        write_regs(reg_set_t'{tile: 2, cx: 1, cz: 1, detail: 1, r0: 0, r1: 1, r2: 2, r3: 2});
        send_load(-1, 1, 0, 1, 0, 0);
        send_steps(7);
    endtask

    // The tile shrinks while the cursor sits deep in a tile, so the cursor
    // lies beyond the new tile end and must move on at once.
    task automatic test_live_resize();
        write_regs(reg_set_t'{tile: 8, cx: 2, cz: 2, detail: 1, r0: 1, r1: 2, r2: 3, r3: 4});
        send_load(0, 7, 0, 7, 0, 0);
        send_steps(3);
        write_regs(reg_set_t'{tile: 2, cx: 2, cz: 2, detail: 1, r0: 1, r1: 2, r2: 3, r3: 4});
        send_steps(3);
        write_regs(reg_set_t'{tile: 0, cx: 2, cz: 2, detail: 0, r0: 1, r1: 2, r2: 3, r3: 4});
        send_steps(1);
    endtask

    task automatic test_coordinate_extremes();
        write_regs(reg_set_t'{tile: 8191, cx: COORD_MIN, cz: COORD_MAX, detail: 1,
                              r0: 65535, r1: 65535, r2: 65535, r3: 65535});
        send_load(COORD_MAX - 1, COORD_MAX, COORD_MIN, COORD_MIN, SEC_MIN, SEC_MIN + 1);
        send_steps(5);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int used;
        int seg_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
            write_regs(random_setting());
            seg_sent = 0;
            while (seg_sent < SEGMENT_ITEMS) begin
                run_region(used);
                seg_sent += used;
            end
        end
    endtask

    task automatic test_long_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_regs(reg_set_t'{tile: 4, cx: 3, cz: 3, detail: 1, r0: 0, r1: 1, r2: 2, r3: 3});
        long_hold = 1'b1;
        send_load(0, 7, 0, 7, 0, 0);
        send_steps(64);
        long_hold = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unloaded_and_empty();
        test_tile_walk();
        test_live_resize();
        test_coordinate_extremes();
        test_random_traffic(6, 48);
        test_random_traffic(48, 6);
        test_random_traffic(0, 0);
        test_long_stall();
        wait_idle();
        $display("Sent %0d beats (%0d loads) under %0d register settings and checked %0d tasks,",
                 beats_sent, loads_sent, settings_applied, tasks_checked);
        $display("with uneven idling on both sides and one long receiver hold; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_tasks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: tiled_scan_lod_task_generator.f
+incdir+rtl/core
rtl/core/tslg_pkg.sv
rtl/core/tslg_traverse.sv
rtl/core/tslg_classify.sv
rtl/core/tiled_scan_lod_task_generator.sv
test/tb_tiled_scan_lod_task_generator.sv
